/* rtl/fvn_pkg.sv */
package fvn_pkg;

  localparam int COORD_WIDTH  = 12;
  localparam int FRAC_BITS    = 16;
  localparam int LATTICE_BITS = 24;
  localparam int OUT_BITS     = 16;
  localparam int SEED_WIDTH   = 32;
  localparam int GRAIN_WIDTH  = 8;
  localparam int OCTAVES      = 3;
  localparam int NUM_WIDTH    = COORD_WIDTH + OCTAVES - 1;
  localparam int CFG_WIDTH    = 32;
  localparam int CFG_IDX_W    = 1;
  localparam int FW           = FRAC_BITS;
  localparam int LW           = LATTICE_BITS;

  localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
  localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

  localparam logic [CFG_IDX_W-1:0] REG_SEED  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAIN = 1'd1;

  localparam int DIV_STEPS = NUM_WIDTH + FRAC_BITS;

endpackage

/* rtl/fvn_if.sv */
interface fvn_in_if;
  import fvn_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] tile_x;
  logic [COORD_WIDTH-1:0] tile_y;
  modport source (output valid, tile_x, tile_y, input ready);
  modport sink (input valid, tile_x, tile_y, output ready);
endinterface

interface fvn_out_if;
  import fvn_pkg::*;
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

/* rtl/fvn_div.sv */
// restoring divider, one quotient bit per stage: {num, FRAC zeros} / g
module fvn_div
  import fvn_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic [NUM_WIDTH-1:0]   num,
  input  logic [GRAIN_WIDTH-1:0] den,
  output logic [NUM_WIDTH-1:0]   quot,
  output logic [FRAC_BITS-1:0]   frac
);

  logic [GRAIN_WIDTH-1:0] rem [DIV_STEPS];
  logic [DIV_STEPS-1:0]   dvd [DIV_STEPS];
  logic [DIV_STEPS-1:0]   quo [DIV_STEPS];
  logic [GRAIN_WIDTH-1:0] dsr [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [GRAIN_WIDTH-1:0] rem_in;
    logic [GRAIN_WIDTH-1:0] dsr_in;
    logic [DIV_STEPS-1:0]   dvd_in;
    logic [DIV_STEPS-1:0]   quo_in;
    logic [GRAIN_WIDTH:0]   trial;
    logic [GRAIN_WIDTH:0]   diff;
    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = {num, {FRAC_BITS{1'b0}}};
      assign quo_in = '0;
      assign dsr_in = den;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign dvd_in = dvd[i-1];
      assign quo_in = quo[i-1];
      assign dsr_in = dsr[i-1];
    end
    assign trial = {rem_in, dvd_in[DIV_STEPS-1]};
    assign diff  = trial - {1'b0, dsr_in};
    always_ff @(posedge clk) begin
      if (en) begin
        dsr[i] <= dsr_in;
        dvd[i] <= {dvd_in[DIV_STEPS-2:0], 1'b0};
        if (!diff[GRAIN_WIDTH]) begin
          rem[i] <= diff[GRAIN_WIDTH-1:0];
          quo[i] <= {quo_in[DIV_STEPS-2:0], 1'b1};
        end else begin
          rem[i] <= trial[GRAIN_WIDTH-1:0];
          quo[i] <= {quo_in[DIV_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  assign quot = quo[DIV_STEPS-1][DIV_STEPS-1:FRAC_BITS];
  assign frac = quo[DIV_STEPS-1][FRAC_BITS-1:0];

endmodule

/* rtl/fvn_octave.sv */
// hash, smoothstep and bilinear blend of one octave; 5 stages
module fvn_octave
  import fvn_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [NUM_WIDTH-1:0]  ix,
  input  logic [NUM_WIDTH-1:0]  iy,
  input  logic [FRAC_BITS-1:0]  fx,
  input  logic [FRAC_BITS-1:0]  fy,
  input  logic [SEED_WIDTH-1:0] seed,
  output logic [LW-1:0]         value
);

  localparam logic [FW:0] ONE = {1'b1, {FW{1'b0}}};

  logic [31:0] hx0, hx1, hy0, hy1;
  logic [31:0] s1_hx0, s1_hx1, s1_hy0, s1_hy1, s1_seed;
  logic [FW-1:0] s1_t, s1_u;
  logic [FW+1:0] s1_wx, s1_wy;
  logic [31:0] s2_h [4];
  logic [FW:0] s2_sx, s2_sy;
  logic [LW-1:0] s3_v [4];
  logic [FW:0] s3_sx, s3_sy;
  logic [LW-1:0] s4_a, s4_b;
  logic [FW:0] s4_sy;
  logic [2*FW-1:0] sqx, sqy;
  logic [2*FW+1:0] smx, smy;
  logic [31:0] pre [4];
  logic [31:0] mix [4];
  logic [LW+FW:0] bla, blb, blo;

  always_comb begin
    hx0 = 32'(ix) * HASH_MUL_X;
    hx1 = 32'(ix + NUM_WIDTH'(1)) * HASH_MUL_X;
    hy0 = 32'(iy) * HASH_MUL_Y;
    hy1 = 32'(iy + NUM_WIDTH'(1)) * HASH_MUL_Y;
    sqx = fx * fx;
    sqy = fy * fy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_hx0 <= hx0;
      s1_hx1 <= hx1;
      s1_hy0 <= hy0;
      s1_hy1 <= hy1;
      s1_seed <= seed;
      s1_t <= sqx[2*FW-1:FW];
      s1_u <= sqy[2*FW-1:FW];
      s1_wx <= (FW+2)'(3) * (FW+2)'(ONE) - {1'b0, fx, 1'b0};
      s1_wy <= (FW+2)'(3) * (FW+2)'(ONE) - {1'b0, fy, 1'b0};
    end
  end

  always_comb begin
    smx = s1_t * s1_wx;
    smy = s1_u * s1_wy;
    pre[0] = s1_seed + s1_hx0 + s1_hy0;
    pre[1] = s1_seed + s1_hx1 + s1_hy0;
    pre[2] = s1_seed + s1_hx0 + s1_hy1;
    pre[3] = s1_seed + s1_hx1 + s1_hy1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) s2_h[i] <= pre[i] ^ (pre[i] >> 13);
      s2_sx <= smx[2*FW:FW];
      s2_sy <= smy[2*FW:FW];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) mix[i] = s2_h[i] * HASH_MUL_MIX;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) s3_v[i] <= LW'(mix[i] ^ (mix[i] >> 16));
      s3_sx <= s2_sx;
      s3_sy <= s2_sy;
    end
  end

  always_comb begin
    bla = s3_v[0] * (ONE - s3_sx) + s3_v[1] * s3_sx;
    blb = s3_v[2] * (ONE - s3_sx) + s3_v[3] * s3_sx;
    blo = s4_a * (ONE - s4_sy) + s4_b * s4_sy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_a <= bla[LW+FW-1:FW];
      s4_b <= blb[LW+FW-1:FW];
      s4_sy <= s3_sy;
      value <= blo[LW+FW-1:FW];
    end
  end

endmodule

/* rtl/fractal_value_noise_top.sv */
// channel   dir  payload                      handshake
// in        in   tile_x[11:0], tile_y[11:0]   valid/ready
// out       out  noise_value[15:0]            valid/ready
// cfg       in   cfg_we, cfg_idx, cfg_data    write enable only
// One item per cycle unless the output stalls; path: divider chain, octave
// hash/blend stages, weighted mix and divide by 7, output register.
// Synchronous reset clears valid bits and config (seed 0, grain 2).
// The whole pipe advances when the output register is empty or taken;
// in_ready is that same enable, so a stall freezes every stage.
module fractal_value_noise_top
  import fvn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  fvn_in_if.sink               in_ch,
  fvn_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  localparam int LAT = DIV_STEPS + 7;

  logic [SEED_WIDTH-1:0] noise_seed;
  logic [GRAIN_WIDTH-1:0] grain_size;
  logic [GRAIN_WIDTH-1:0] grain_eff;
  logic en;
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed <= '0;
      grain_size <= GRAIN_WIDTH'(2);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SEED:  noise_seed <= cfg_data;
        REG_GRAIN: grain_size <= cfg_data[GRAIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign grain_eff = (grain_size < GRAIN_WIDTH'(2)) ? GRAIN_WIDTH'(2) : grain_size;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  logic [NUM_WIDTH-1:0] cx [OCTAVES];
  logic [NUM_WIDTH-1:0] cy [OCTAVES];
  logic [FRAC_BITS-1:0] fx [OCTAVES];
  logic [FRAC_BITS-1:0] fy [OCTAVES];
  logic [LW-1:0] ov [OCTAVES];

  for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
    logic [SEED_WIDTH-1:0] sd;
    assign sd = noise_seed + SEED_WIDTH'(k);
    fvn_div u_dx (.clk, .en,
      .num(NUM_WIDTH'(in_ch.tile_x) << k), .den(grain_eff),
      .quot(cx[k]), .frac(fx[k]));
    fvn_div u_dy (.clk, .en,
      .num(NUM_WIDTH'(in_ch.tile_y) << k), .den(grain_eff),
      .quot(cy[k]), .frac(fy[k]));
    fvn_octave u_oct (.clk, .en, .ix(cx[k]), .iy(cy[k]),
      .fx(fx[k]), .fy(fy[k]), .seed(sd), .value(ov[k]));
  end

  // weighted sum, then /7 by reciprocal with one correction
  logic [LW+2:0] sum;
  logic [LW+2:0] qest;
  logic [2*(LW+3)+2:0] prod;
  logic [LW+2:0] rem7;
  logic [LW+2:0] q7;

  always_ff @(posedge clk) begin
    if (en) sum <= {ov[0], 2'b00} + {1'b0, ov[1], 1'b0} + (LW+3)'(ov[2]);
  end

  // floor(sum/7) ~= sum * ceil(2^(LW+6)/7) >> (LW+6) may be off by one
  localparam int SH = LW + 6;
  localparam logic [LW+5:0] RECIP = (LW+6)'(((64'd1 << SH) + 64'd6) / 64'd7);
  assign prod = sum * RECIP;
  assign qest = prod[SH+LW+2:SH];

  always_ff @(posedge clk) begin
    if (en) begin
      rem7 <= sum;
      q7 <= qest;
    end
  end

  logic [LW+5:0] q7x7;
  logic [LW+2:0] mval;
  assign q7x7 = (LW+6)'(q7) * (LW+6)'(7);
  assign mval = (q7x7 > (LW+6)'(rem7)) ? q7 - (LW+3)'(1) : q7;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_ch.valid};
  end

  always_ff @(posedge clk) begin
    if (en) out_ch.noise_value <= mval[LW-1:LW-OUT_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (en) out_ch.valid <= vld[LAT-1];
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.noise_value))
    else $error("result lost during stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("input ready disagrees with pipe enable");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_ch.valid)
    else $error("result after reset");

endmodule

/* tb/tb_top.sv */
module tb_top;
  import fvn_pkg::*;

  class noise_scoreboard;
    logic [OUT_BITS-1:0] pending[$];
    int errors;
    int checked;

    function new();
      errors = 0;
      checked = 0;
    endfunction

    function void note_sample(logic [OUT_BITS-1:0] v);
      pending = {pending, v};
    endfunction

    function void check_sample(logic [OUT_BITS-1:0] got);
      logic [OUT_BITS-1:0] want;
      if (pending.size() == 0) begin
        $error("noise_value: unexpected item, actual %0h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want !== got) begin
        $error("noise_value: expected %0h actual %0h", want, got);
        errors++;
      end
    endfunction
  endclass

  localparam int LAT = DIV_STEPS + 8;
  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_SEED;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  fvn_in_if in_ch ();
  fvn_out_if out_ch ();

  fractal_value_noise_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  noise_scoreboard sb = new();
  logic [31:0] seed_q = 0;
  logic [7:0] grain_q = 2;
  bit hold_out = 0;
  int idle_cycles = 0;
  int n_items = 0;

  function automatic logic [63:0] lattice(logic [31:0] ix, logic [31:0] iy,
                                          logic [31:0] s);
    logic [31:0] h;
    h = s + ix * HASH_MUL_X + iy * HASH_MUL_Y;
    h = (h ^ (h >> 13)) * HASH_MUL_MIX;
    h = h ^ (h >> 16);
    return {40'd0, h[23:0]};
  endfunction

  function automatic logic [63:0] smoothstep(logic [63:0] f);
    logic [63:0] t;
    t = (f * f) >> FRAC_BITS;
    return (t * ((64'd3 << FRAC_BITS) - 2 * f)) >> FRAC_BITS;
  endfunction

  function automatic logic [63:0] lerp(logic [63:0] a, logic [63:0] b, logic [63:0] s);
    return (a * ((64'd1 << FRAC_BITS) - s) + b * s) >> FRAC_BITS;
  endfunction

  function automatic logic [63:0] octave_value(logic [31:0] x, logic [31:0] y, int k,
                                               logic [31:0] g, logic [31:0] s);
    logic [31:0] nx, ny, ix, iy;
    logic [63:0] sx, sy, a, b;
    nx = x << k;
    ny = y << k;
    ix = nx / g;
    iy = ny / g;
    sx = smoothstep((64'(nx % g) << FRAC_BITS) / g);
    sy = smoothstep((64'(ny % g) << FRAC_BITS) / g);
    a = lerp(lattice(ix, iy, s), lattice(ix + 1, iy, s), sx);
    b = lerp(lattice(ix, iy + 1, s), lattice(ix + 1, iy + 1, s), sx);
    return lerp(a, b, sy);
  endfunction

  function automatic logic [OUT_BITS-1:0] fractal_noise(logic [COORD_WIDTH-1:0] x,
                                                        logic [COORD_WIDTH-1:0] y);
    logic [31:0] g;
    logic [31:0] xw;
    logic [31:0] yw;
    logic [63:0] m;
    xw = 32'(x);
    yw = 32'(y);
    g = (grain_q < 2) ? 32'd2 : 32'(grain_q);
    m = (4 * octave_value(xw, yw, 0, g, seed_q) + 2 * octave_value(xw, yw, 1, g, seed_q + 1)
         + octave_value(xw, yw, 2, g, seed_q + 2)) / 7;
    return OUT_BITS'(m >> (LATTICE_BITS - OUT_BITS));
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_WIDTH-1:0] v);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_SEED) seed_q = v;
    else grain_q = v[7:0];
    @(posedge clk);
  endtask

  task automatic send_tile(logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y,
                           bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.tile_x <= x;
    in_ch.tile_y <= y;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(fractal_noise(x, y));
    n_items++;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_sample(out_ch.noise_value);
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    int g;
    out_ch.ready = 0;
    @(posedge clk);
    while (1) begin
      if (hold_out) begin
        out_ch.ready <= 0;
        repeat (300) @(posedge clk);
        hold_out = 0;
      end
      g = rst ? 0 : gap_len();
      if (g > 0) begin
        out_ch.ready <= 0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    logic [31:0] seeds[4];
    logic [7:0] grains[6];
    int p;
    in_ch.valid = 0;
    in_ch.tile_x = '0;
    in_ch.tile_y = '0;
    seeds = '{32'd0, 32'hffff_ffff, 32'hffff_fffe, 32'h1234_5678};
    grains = '{8'd2, 8'd0, 8'd1, 8'd255, 8'd3, 8'd16};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_tile(0, 0, 0);
    send_tile(12'hfff, 12'hfff, 0);
    send_tile(12'hfff, 0, 0);
    send_tile(0, 12'hfff, 0);
    drain();
    for (p = 0; p < 6; p++) begin
      write_reg(REG_SEED, seeds[p % 4]);
      write_reg(REG_GRAIN, 32'(grains[p]));
      send_tile(0, 0, 0);
      send_tile(12'hfff, 12'hfff, 0);
      send_tile(12'haaa, 12'h555, 0);
      drain();
    end
    for (p = 0; p < 8; p++) begin
      write_reg(REG_SEED, $urandom());
      write_reg(REG_GRAIN, (p == 7) ? 32'd255 : $urandom_range(0, 255));
      if (p == 2) hold_out = 1;
      repeat (140) begin
        if ($urandom_range(0, 5) == 0) send_tile(0, 0, 1);
        else send_tile(12'($urandom()), 12'($urandom()), (p % 3) != 1);
      end
      drain();
    end
    $display("tb_top: %0d items sent, %0d results checked over 15 register settings",
             n_items, sb.checked);
    $display("tb_top: grain extremes 0/1/255, seed wrap, long output stall covered");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
